@@ design/emc_pkg.sv @@
// Shared constants and types for the energy-momentum combiner.
`timescale 1ns / 1ps
package emc_pkg;

    // Codes of the source_taken result field.
    localparam logic [1:0] SRC_CALO  = 2'd0;
    localparam logic [1:0] SRC_TRACK = 2'd1;
    localparam logic [1:0] SRC_MEAN  = 2'd2;

    // Energy source register code that selects the regression pair.
    localparam logic [1:0] ES_REGRESSION = 2'd2;

    // Electron classes with fallback rules.
    localparam logic [2:0] CLASS_HIGH_FALLBACK = 3'd0;
    localparam logic [2:0] CLASS_LOW_FALLBACK  = 3'd3;
    localparam logic [2:0] CLASS_WIDE_FALLBACK = 3'd4;

    // Depth of the queue between the classifier and the divider pipeline.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic e_large;
        logic p_large;
        logic e_zero;
        logic p_zero;
        logic e_gt_p;
        logic e_eq_p;
        logic ratio_low;
        logic below_15;
        logic below_18;
        logic below_13;
        logic below_60;
    } t_flags;

endpackage

@@ design/emc_queue.sv @@
// Small word queue between the classifier front end and the divider back end.
`timescale 1ns / 1ps
module emc_queue import emc_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty)
        else $error("queue empty after a push");

    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push && r_count == (QUEUE_AW+1)'(1)) |=> o_empty)
        else $error("queue not empty after popping its last word");

endmodule

@@ design/emc_front.sv @@
// Front end: energy selection, products, outlier test and choice of result.
`timescale 1ns / 1ps
module emc_front import emc_pkg::*; #(
    parameter int VALUE_BITS    = 20,
    parameter int FRACTION_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_corrected_energy,
    input  logic [VALUE_BITS-1:0]   i_corrected_energy_error,
    input  logic [VALUE_BITS-1:0]   i_regression_energy,
    input  logic [VALUE_BITS-1:0]   i_regression_energy_error,
    input  logic [VALUE_BITS-1:0]   i_track_momentum,
    input  logic [VALUE_BITS-1:0]   i_track_momentum_error,
    input  logic [2:0]              i_electron_class,
    input  logic                    i_is_barrel,
    output logic                    o_valid,
    input  logic                    i_full,
    output logic [11*VALUE_BITS+4:0] o_word
);

    localparam int V  = VALUE_BITS;
    localparam int W2 = 2 * V;
    localparam int W4 = 4 * V;
    localparam int NW = 3 * V + 1;
    localparam int DW = 2 * V + 1;
    localparam int XW = 4 * V + 6;
    localparam int TW = V + FRACTION_BITS + 6;
    localparam int RW = V + 5;
    localparam logic [TW-1:0] TH15 = TW'(15) << FRACTION_BITS;
    localparam logic [TW-1:0] TH18 = TW'(18) << FRACTION_BITS;
    localparam logic [TW-1:0] TH13 = TW'(13) << FRACTION_BITS;
    localparam logic [TW-1:0] TH60 = TW'(60) << FRACTION_BITS;

    typedef struct packed {
        logic [V-1:0] e;
        logic [V-1:0] se;
        logic [V-1:0] p;
        logic [V-1:0] sp;
        logic [V-1:0] mid;
        logic [2:0]   cls;
        logic         barrel;
    } t_base;

    logic [1:0] r_energy_source;
    logic       fen;

    // Stage 0: selected measurements.
    logic         r0_v;
    logic [V-1:0] r0_e, r0_se, r0_p, r0_sp;
    logic [2:0]   r0_cls;
    logic         r0_barrel;

    // Stage 1: flags and first products.
    logic         r1_v;
    t_base        r1_base;
    t_flags       r1_flags;
    logic [W2-1:0] r1_a, r1_b, r1_c, r1_s, r1_ve, r1_vp;

    // Stage 2: partial products of the squares and of the numerator.
    logic         r2_v;
    t_base        r2_base;
    t_flags       r2_flags;
    logic         r2_take_p;
    logic [W2-1:0] r2_a_hh, r2_a_hl, r2_a_ll;
    logic [W2-1:0] r2_b_hh, r2_b_hl, r2_b_ll;
    logic [W2-1:0] r2_c_hh, r2_c_hl, r2_c_ll;
    logic [W2-1:0] r2_s_hh, r2_s_hl, r2_s_ll;
    logic [W2-1:0] r2_nh, r2_nl, r2_mh, r2_ml;
    logic [DW-1:0] r2_den;

    // Stage 3: assembled wide values.
    logic         r3_v;
    t_base        r3_base;
    t_flags       r3_flags;
    logic         r3_take_p;
    logic [W4-1:0] r3_a2, r3_b2, r3_c2, r3_prod;
    logic [NW-1:0] r3_num;
    logic [DW-1:0] r3_den;

    // Stage 4: decision, handed to the queue.
    logic          r4_v;
    logic [1:0]    r4_src;
    logic [V-1:0]  r4_val, r4_err;
    logic          r4_div;
    logic [NW-1:0] r4_num;
    logic [DW-1:0] r4_den;
    logic [W4-1:0] r4_prod;

    logic [V-1:0]  sel_e, sel_se;
    logic [V-1:0]  d;
    t_flags        flags;
    logic [V-1:0]  mid;

    logic [XW-1:0] lhs, rhs, bc;
    logic          outlier;
    logic          low_fb;
    logic [1:0]    n_src;
    logic [V-1:0]  n_val, n_err;
    logic          n_div;

    function automatic logic [W4-1:0] square_sum(logic [W2-1:0] hh, logic [W2-1:0] hl,
                                                 logic [W2-1:0] ll);
        return (W4'(hh) << W2) + (W4'(hl) << (V + 1)) + W4'(ll);
    endfunction

    assign fen     = !r4_v || !i_full;
    assign o_ready = fen;
    assign o_valid = r4_v;
    assign o_word  = {r4_src, r4_val, r4_err, r4_div, r4_num, r4_den, r4_prod};

    assign sel_e  = (r_energy_source == ES_REGRESSION) ? i_regression_energy
                                                       : i_corrected_energy;
    assign sel_se = (r_energy_source == ES_REGRESSION) ? i_regression_energy_error
                                                       : i_corrected_energy_error;

    always_comb begin
        flags.e_zero    = (r0_e == '0);
        flags.p_zero    = (r0_p == '0);
        flags.e_large   = flags.e_zero || ({r0_se, 1'b0} > {1'b0, r0_e});
        flags.p_large   = flags.p_zero || ({r0_sp, 1'b0} > {1'b0, r0_p});
        flags.e_gt_p    = (r0_e > r0_p);
        flags.e_eq_p    = (r0_e == r0_p);
        flags.ratio_low = (RW'(r0_e) * RW'(20)) < (RW'(r0_p) * RW'(23));
        flags.below_15  = TW'(r0_e) < TH15;
        flags.below_18  = TW'(r0_e) < TH18;
        flags.below_13  = TW'(r0_e) < TH13;
        flags.below_60  = TW'(r0_e) < TH60;
        d   = flags.e_gt_p ? (r0_e - r0_p) : (r0_p - r0_e);
        mid = V'(((V+1)'(r0_e) + (V+1)'(r0_p)) >> 1);
    end

    always_comb begin
        bc      = XW'(r3_b2) + XW'(r3_c2);
        lhs     = XW'(r3_a2) << 2;
        rhs     = (bc << 4) + (bc << 3) + bc;
        outlier = !r3_flags.e_eq_p && (lhs > rhs);
        low_fb  = 1'b0;
        if (r3_base.cls == CLASS_LOW_FALLBACK) begin
            low_fb = r3_base.barrel ? r3_flags.below_18 : r3_flags.below_13;
        end else if (r3_base.cls == CLASS_WIDE_FALLBACK) begin
            low_fb = r3_flags.below_60;
        end
        n_src = SRC_CALO;
        n_val = r3_base.e;
        n_err = r3_base.se;
        n_div = 1'b0;
        if (r3_flags.p_large && !r3_flags.e_large) begin
            n_src = SRC_CALO;
        end else if (!r3_flags.p_large && r3_flags.e_large) begin
            n_src = SRC_TRACK;
        end else if (r3_flags.p_large && r3_flags.e_large) begin
            if (r3_take_p) begin
                n_src = SRC_TRACK;
            end
        end else if (outlier && r3_flags.e_gt_p) begin
            if (r3_base.cls == CLASS_HIGH_FALLBACK && r3_base.barrel &&
                r3_flags.ratio_low && r3_flags.below_15) begin
                n_src = SRC_TRACK;
            end
        end else if (outlier) begin
            if (low_fb) begin
                n_src = SRC_TRACK;
            end
        end else begin
            // Weighted mean by division; plain average when both errors are zero.
            n_src = SRC_MEAN;
            n_val = r3_base.mid;
            n_err = '0;
            n_div = (r3_den != '0);
        end
        if (n_src == SRC_TRACK) begin
            n_val = r3_base.p;
            n_err = r3_base.sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_source <= 2'd1;
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_energy_source <= i_cfg_data;
            end
            if (fen) begin
                r0_v <= i_valid;
                r1_v <= r0_v;
                r2_v <= r1_v;
                r3_v <= r2_v;
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r0_e      <= sel_e;
            r0_se     <= sel_se;
            r0_p      <= i_track_momentum;
            r0_sp     <= i_track_momentum_error;
            r0_cls    <= i_electron_class;
            r0_barrel <= i_is_barrel;

            r1_base  <= '{e: r0_e, se: r0_se, p: r0_p, sp: r0_sp, mid: mid,
                          cls: r0_cls, barrel: r0_barrel};
            r1_flags <= flags;
            r1_a     <= W2'(d) * W2'(r0_p);
            r1_b     <= W2'(r0_se) * W2'(r0_p);
            r1_c     <= W2'(r0_e) * W2'(r0_sp);
            r1_s     <= W2'(r0_se) * W2'(r0_sp);
            r1_ve    <= W2'(r0_se) * W2'(r0_se);
            r1_vp    <= W2'(r0_sp) * W2'(r0_sp);

            // In the both-large case the tracker wins when sp*E < sE*p.
            r2_base   <= r1_base;
            r2_flags  <= r1_flags;
            r2_take_p <= r1_flags.e_zero ? !r1_flags.p_zero
                       : (!r1_flags.p_zero && (r1_c < r1_b));
            r2_a_hh <= W2'(r1_a[W2-1:V]) * W2'(r1_a[W2-1:V]);
            r2_a_hl <= W2'(r1_a[W2-1:V]) * W2'(r1_a[V-1:0]);
            r2_a_ll <= W2'(r1_a[V-1:0]) * W2'(r1_a[V-1:0]);
            r2_b_hh <= W2'(r1_b[W2-1:V]) * W2'(r1_b[W2-1:V]);
            r2_b_hl <= W2'(r1_b[W2-1:V]) * W2'(r1_b[V-1:0]);
            r2_b_ll <= W2'(r1_b[V-1:0]) * W2'(r1_b[V-1:0]);
            r2_c_hh <= W2'(r1_c[W2-1:V]) * W2'(r1_c[W2-1:V]);
            r2_c_hl <= W2'(r1_c[W2-1:V]) * W2'(r1_c[V-1:0]);
            r2_c_ll <= W2'(r1_c[V-1:0]) * W2'(r1_c[V-1:0]);
            r2_s_hh <= W2'(r1_s[W2-1:V]) * W2'(r1_s[W2-1:V]);
            r2_s_hl <= W2'(r1_s[W2-1:V]) * W2'(r1_s[V-1:0]);
            r2_s_ll <= W2'(r1_s[V-1:0]) * W2'(r1_s[V-1:0]);
            r2_nh   <= W2'(r1_base.e) * W2'(r1_vp[W2-1:V]);
            r2_nl   <= W2'(r1_base.e) * W2'(r1_vp[V-1:0]);
            r2_mh   <= W2'(r1_base.p) * W2'(r1_ve[W2-1:V]);
            r2_ml   <= W2'(r1_base.p) * W2'(r1_ve[V-1:0]);
            r2_den  <= DW'(r1_ve) + DW'(r1_vp);

            r3_base   <= r2_base;
            r3_flags  <= r2_flags;
            r3_take_p <= r2_take_p;
            r3_a2     <= square_sum(r2_a_hh, r2_a_hl, r2_a_ll);
            r3_b2     <= square_sum(r2_b_hh, r2_b_hl, r2_b_ll);
            r3_c2     <= square_sum(r2_c_hh, r2_c_hl, r2_c_ll);
            r3_prod   <= square_sum(r2_s_hh, r2_s_hl, r2_s_ll);
            r3_num    <= (NW'(r2_nh) << V) + NW'(r2_nl) + (NW'(r2_mh) << V) + NW'(r2_ml);
            r3_den    <= r2_den;

            r4_src  <= n_src;
            r4_val  <= n_val;
            r4_err  <= n_err;
            r4_div  <= n_div;
            r4_num  <= r3_num;
            r4_den  <= r3_den;
            r4_prod <= r3_prod;
        end
    end

endmodule

@@ design/emc_back.sv @@
// Back end: bit-per-stage division pipelines and square root for the weighted mean.
`timescale 1ns / 1ps
module emc_back import emc_pkg::*; #(
    parameter int VALUE_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic [11*VALUE_BITS+4:0] i_word,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [VALUE_BITS-1:0]    o_combined_value,
    output logic [VALUE_BITS-1:0]    o_combined_error,
    output logic [1:0]               o_source_taken
);

    localparam int V  = VALUE_BITS;
    localparam int W2 = 2 * V;
    localparam int W4 = 4 * V;
    localparam int NW = 3 * V + 1;
    localparam int DW = 2 * V + 1;
    localparam int NS = 3 * V;

    typedef struct packed {
        logic          v;
        logic          div;
        logic [1:0]    src;
        logic [V-1:0]  val;
        logic [V-1:0]  err;
        logic [DW-1:0] den;
        logic [DW-1:0] nrem;
        logic [V-1:0]  nlo;
        logic [V-1:0]  nq;
        logic [DW-1:0] prem;
        logic [W2-1:0] plo;
        logic [W2-1:0] pq;
        logic [W2-1:0] srad;
        logic [V:0]    srem;
        logic [V-1:0]  sroot;
    } t_stage;

    logic [1:0]    h_src;
    logic [V-1:0]  h_val, h_err;
    logic          h_div;
    logic [NW-1:0] h_num;
    logic [DW-1:0] h_den;
    logic [W4-1:0] h_prod;
    t_stage        entry;
    t_stage        r_st [NS];
    t_stage        n_st [NS];
    logic          en;
    logic          r_out_v;
    logic [V-1:0]  r_out_val, r_out_err;
    logic [1:0]    r_out_src;

    // Stages below V divide the numerator, below 2V the error product; the
    // last V stages take the integer square root of the second quotient.
    function automatic t_stage step(t_stage s, int k);
        t_stage        r;
        logic [DW:0]   t;
        logic [V+2:0]  u;
        logic [V+2:0]  trial;
        r = s;
        if (k < V) begin
            t = {s.nrem, s.nlo[V-1]};
            if (t >= {1'b0, s.den}) begin
                r.nrem = DW'(t - {1'b0, s.den});
                r.nq   = {s.nq[V-2:0], 1'b1};
            end else begin
                r.nrem = t[DW-1:0];
                r.nq   = {s.nq[V-2:0], 1'b0};
            end
            r.nlo = s.nlo << 1;
        end
        if (k < W2) begin
            t = {s.prem, s.plo[W2-1]};
            if (t >= {1'b0, s.den}) begin
                r.prem = DW'(t - {1'b0, s.den});
                r.pq   = {s.pq[W2-2:0], 1'b1};
            end else begin
                r.prem = t[DW-1:0];
                r.pq   = {s.pq[W2-2:0], 1'b0};
            end
            r.plo = s.plo << 1;
            if (k == W2 - 1) begin
                r.srad = r.pq;
            end
        end else begin
            u     = {s.srem, s.srad[W2-1 -: 2]};
            trial = {1'b0, s.sroot, 2'b01};
            if (u >= trial) begin
                r.srem  = (V+1)'(u - trial);
                r.sroot = {s.sroot[V-2:0], 1'b1};
            end else begin
                r.srem  = u[V:0];
                r.sroot = {s.sroot[V-2:0], 1'b0};
            end
            r.srad = s.srad << 2;
        end
        return r;
    endfunction

    assign {h_src, h_val, h_err, h_div, h_num, h_den, h_prod} = i_word;

    assign en    = !r_out_v || i_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        entry.v     = !i_empty;
        entry.div   = h_div;
        entry.src   = h_src;
        entry.val   = h_val;
        entry.err   = h_err;
        entry.den   = h_den;
        entry.nrem  = h_num[NW-1:V];
        entry.nlo   = h_num[V-1:0];
        entry.nq    = '0;
        entry.prem  = {1'b0, h_prod[W4-1:W2]};
        entry.plo   = h_prod[W2-1:0];
        entry.pq    = '0;
        entry.srad  = '0;
        entry.srem  = '0;
        entry.sroot = '0;
        n_st[0] = step(entry, 0);
        for (int k = 1; k < NS; k++) begin
            n_st[k] = step(r_st[k-1], k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k].v <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_st    <= n_st;
            r_out_v <= r_st[NS-1].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_src <= r_st[NS-1].src;
            r_out_val <= r_st[NS-1].div ? r_st[NS-1].nq : r_st[NS-1].val;
            r_out_err <= r_st[NS-1].div ? r_st[NS-1].sroot : r_st[NS-1].err;
        end
    end

    assign o_valid          = r_out_v;
    assign o_combined_value = r_out_val;
    assign o_combined_error = r_out_err;
    assign o_source_taken   = r_out_src;

endmodule

@@ design/energy_momentum_combiner.sv @@
// Top level of the energy-momentum combiner.
//
// Input channel: i_valid / o_ready carry one word with two calorimeter energy
// estimates and their errors, the track momentum and its error, the electron
// class and the barrel flag. Output channel: o_valid / i_ready carry the
// combined value, its error and the source code of the result.
// i_cfg_we writes i_cfg_data into the energy source register (reset value 1);
// write it only while no word is in flight.
// Throughput is one word per cycle while the receiver does not stall. A word
// passes through five front stages, the queue, VALUE_BITS division stages
// plus VALUE_BITS more for the error quotient, VALUE_BITS square-root stages
// and the output register; the error quotient and root chain are the longest.
// A four-word queue separates the front stages from the divider pipeline.
// When the receiver stalls, the divider pipeline holds, the queue fills, and
// then o_ready falls. Reset is synchronous and active low; it empties all
// stages and the queue and restores the energy source register.
`timescale 1ns / 1ps
module energy_momentum_combiner #(
    parameter int VALUE_BITS    = 20,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_corrected_energy,
    input  logic [VALUE_BITS-1:0] i_corrected_energy_error,
    input  logic [VALUE_BITS-1:0] i_regression_energy,
    input  logic [VALUE_BITS-1:0] i_regression_energy_error,
    input  logic [VALUE_BITS-1:0] i_track_momentum,
    input  logic [VALUE_BITS-1:0] i_track_momentum_error,
    input  logic [2:0]            i_electron_class,
    input  logic                  i_is_barrel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_BITS-1:0] o_combined_value,
    output logic [VALUE_BITS-1:0] o_combined_error,
    output logic [1:0]            o_source_taken
);

    localparam int QW = 11 * VALUE_BITS + 5;

    logic          f_valid;
    logic [QW-1:0] f_word;
    logic [QW-1:0] q_word;
    logic          q_full, q_empty, q_pop;

    emc_front #(
        .VALUE_BITS    (VALUE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_cfg_we                  (i_cfg_we),
        .i_cfg_data                (i_cfg_data),
        .i_valid                   (i_valid),
        .o_ready                   (o_ready),
        .i_corrected_energy        (i_corrected_energy),
        .i_corrected_energy_error  (i_corrected_energy_error),
        .i_regression_energy       (i_regression_energy),
        .i_regression_energy_error (i_regression_energy_error),
        .i_track_momentum          (i_track_momentum),
        .i_track_momentum_error    (i_track_momentum_error),
        .i_electron_class          (i_electron_class),
        .i_is_barrel               (i_is_barrel),
        .o_valid                   (f_valid),
        .i_full                    (q_full),
        .o_word                    (f_word)
    );

    emc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_data  (f_word),
        .i_pop   (q_pop),
        .o_data  (q_word),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    emc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_word           (q_word),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_combined_value (o_combined_value),
        .o_combined_error (o_combined_error),
        .o_source_taken   (o_source_taken)
    );

endmodule
